// ===== hdl/efc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package efc_pkg;

  localparam int unsigned FloorW = 3;
  localparam int unsigned PortW  = 8;
  localparam int unsigned ModeW  = 2;

  // Control mode codes; the unused code behaves as homing.
  localparam logic [ModeW-1:0] MODE_HOMING  = 2'd0;
  localparam logic [ModeW-1:0] MODE_WAITING = 2'd1;
  localparam logic [ModeW-1:0] MODE_TRAVEL  = 2'd2;

  // Output port bits (active low unless noted).
  localparam int unsigned OB_C     = 0;
  localparam int unsigned OB_MOTOR = 1;
  localparam int unsigned OB_B     = 2;
  localparam int unsigned OB_DIR   = 3;
  localparam int unsigned OB_A     = 4;
  localparam int unsigned OB_LIGHT = 5;
  localparam int unsigned OB_UP    = 6;
  localparam int unsigned OB_DOWN  = 7;

  // Floor port bits.
  localparam int unsigned FP_DOOR   = 0;
  localparam int unsigned FP_GROUND = 1;
  localparam int unsigned FP_OCCUPY = 2;

  localparam logic [PortW-1:0] NonMarkMask = 8'h55;
  localparam logic [PortW-1:0] AllHigh     = 8'hFF;
  localparam logic [PortW-1:0] DigitMask   = 8'h15;
  localparam logic [PortW-1:0] ArrowMask   = 8'hC0;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [FloorW-1:0] car_floor;
    logic [FloorW-1:0] target_floor;
    logic [PortW-1:0] prev_marks;
    logic [PortW-1:0] out_latch;
  } efc_state_t;

  function automatic logic [PortW-1:0] digit_code(input logic [FloorW-1:0] floor_num);
    logic [PortW-1:0] code;
    code = '0;
    case (floor_num)
      3'd1: code[OB_A] = 1'b1;
      3'd2: code[OB_B] = 1'b1;
      3'd3: begin
        code[OB_A] = 1'b1;
        code[OB_B] = 1'b1;
      end
      3'd4: code[OB_C] = 1'b1;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/efc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface efc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] floor_port;
  logic [7:0] button_port;

  modport source (output valid, output floor_port, output button_port, input ready);
  modport sink (input valid, input floor_port, input button_port, output ready);
endinterface

interface efc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] output_port;

  modport source (output valid, output output_port, input ready);
  modport sink (input valid, input output_port, output ready);
endinterface

`default_nettype wire

// ===== hdl/efc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efc_step #(
  parameter int unsigned FLOORS = 4
) (
  input  efc_pkg::efc_state_t state_i,
  input  logic [7:0]          floor_port_i,
  input  logic [7:0]          button_port_i,
  output efc_pkg::efc_state_t state_o
);
  import efc_pkg::*;

  localparam logic [FloorW-1:0] TopFloor = FloorW'(FLOORS);

  logic [PortW-1:0] marks;
  logic             empty;
  logic             found;
  logic             going_up;
  efc_state_t       nxt;

  assign marks = floor_port_i | NonMarkMask;
  assign empty = floor_port_i[FP_OCCUPY];

  always_comb begin
    nxt      = state_i;
    found    = 1'b0;
    going_up = 1'b0;
    case (state_i.mode)
      MODE_WAITING: begin
        nxt.out_latch[OB_LIGHT] = 1'b1;
        // Lowest pressed call wins; outside buttons when empty, inside when occupied.
        for (int i = 0; i < 4; i++) begin
          if (!found && (i < FLOORS) &&
              !button_port_i[empty ? 2 * i : 2 * i + 1]) begin
            found            = 1'b1;
            nxt.target_floor = FloorW'(i + 1);
            nxt.mode         = MODE_TRAVEL;
          end
        end
      end
      MODE_TRAVEL: begin
        nxt.out_latch[OB_LIGHT] = 1'b0;
        if (floor_port_i[FP_DOOR]) begin
          nxt.out_latch[OB_MOTOR] = 1'b1;
        end else if (state_i.car_floor != state_i.target_floor) begin
          going_up                = state_i.car_floor < state_i.target_floor;
          nxt.out_latch[OB_DIR]   = going_up;
          nxt.out_latch[OB_MOTOR] = 1'b0;
          // A floor is passed when all marks were high and one has just dropped.
          if (state_i.prev_marks == AllHigh && marks != AllHigh) begin
            if (going_up) begin
              if (state_i.car_floor < TopFloor) begin
                nxt.car_floor = state_i.car_floor + 1'b1;
              end
            end else if (state_i.car_floor != '0) begin
              nxt.car_floor = state_i.car_floor - 1'b1;
            end
          end
          nxt.prev_marks = marks;
        end else begin
          nxt.out_latch[OB_MOTOR] = 1'b1;
          nxt.mode                = MODE_WAITING;
        end
      end
      default: begin
        if (!floor_port_i[FP_GROUND]) begin
          nxt.out_latch[OB_MOTOR] = 1'b1;
          nxt.car_floor           = FloorW'(1);
          nxt.mode                = MODE_WAITING;
        end else begin
          nxt.out_latch[OB_MOTOR] = 1'b0;
          nxt.out_latch[OB_DIR]   = 1'b0;
        end
      end
    endcase

    nxt.out_latch = (nxt.out_latch & ~DigitMask) | digit_code(nxt.car_floor);
    // Arrows are only lit while running and both go dark when the motor stops.
    if (!nxt.out_latch[OB_MOTOR]) begin
      if (nxt.out_latch[OB_DIR]) begin
        nxt.out_latch[OB_UP] = 1'b0;
      end else begin
        nxt.out_latch[OB_DOWN] = 1'b0;
      end
    end else begin
      nxt.out_latch = nxt.out_latch | ArrowMask;
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

// ===== hdl/elevator_floor_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: a word accepted is held in the input register, and the result register loads
// from it when the output side is free. One word per cycle is sustained while results
// are taken. While a finished result waits on the output, the input side takes one more
// word and then stalls until the result is taken.
// Reset: homing mode, floor and target zero, previous marks zero, output latch 0xFF,
// both pipeline registers empty.
module elevator_floor_controller_core #(
  parameter int unsigned FLOORS = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  efc_in_if.sink    in_i,
  efc_out_if.source out_o
);
  import efc_pkg::*;

  logic             s1_valid_q;
  logic [PortW-1:0] s1_floor_q;
  logic [PortW-1:0] s1_button_q;
  logic             s1_adv;
  logic             out_valid_q;
  logic [PortW-1:0] out_port_q;
  efc_state_t       state_q;
  efc_state_t       state_d;
  efc_state_t       state_rst;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign state_rst = '{mode: MODE_HOMING, car_floor: '0, target_floor: '0,
                       prev_marks: '0, out_latch: AllHigh};

  efc_step #(
    .FLOORS(FLOORS)
  ) u_step (
    .state_i      (state_q),
    .floor_port_i (s1_floor_q),
    .button_port_i(s1_button_q),
    .state_o      (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= state_rst;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_floor_q  <= in_i.floor_port;
      s1_button_q <= in_i.button_port;
    end
    if (s1_adv) begin
      out_port_q <= state_d.out_latch;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.output_port = out_port_q;

`ifndef SYNTHESIS
  a_floor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.car_floor <= FloorW'(FLOORS))
    else $error("car floor beyond top floor");

  a_wait_motor_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == MODE_WAITING |-> state_q.out_latch[OB_MOTOR])
    else $error("motor running while waiting for a call");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(state_q))
    else $error("state changed without a word being processed");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while the result register is empty");

  a_result_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_port_q == state_q.out_latch)
    else $error("result word differs from output latch");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import efc_pkg::*;

  localparam int unsigned Floors      = 4;
  localparam int unsigned RandomWords = 1280;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PlanRows    = 25;

  // One directed sample; port is only meaningful when typed is set.
  typedef struct packed {
    logic [PortW-1:0] fp;
    logic [PortW-1:0] bp;
    logic             typed;
    logic [PortW-1:0] port;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  efc_in_if  in_bus ();
  efc_out_if out_bus ();

  elevator_floor_controller_core #(
    .FLOORS(Floors)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // Homing, the first call, a climb to floor 3, an occupied ride to floor 4,
  // and a descent back to floor 1 that passes ignored non-mark bits.
  plan_row_t call_plan [PlanRows] = '{
    '{8'hFF, 8'hFF, 1'b1, 8'h60},
    '{8'hFF, 8'h00, 1'b1, 8'h60},
    '{8'hFD, 8'hFF, 1'b1, 8'hF2},
    '{8'hFF, 8'hFF, 1'b1, 8'hF2},
    '{8'hFF, 8'hEF, 1'b0, 8'h00},
    '{8'hFF, 8'hFF, 1'b0, 8'h00},
    '{8'hFE, 8'hFF, 1'b0, 8'h00},
    '{8'hF6, 8'hFF, 1'b0, 8'h00},
    '{8'hF6, 8'hFF, 1'b0, 8'h00},
    '{8'hFE, 8'hFF, 1'b0, 8'h00},
    '{8'hDE, 8'hFF, 1'b0, 8'h00},
    '{8'h00, 8'h00, 1'b0, 8'h00},
    '{8'hFA, 8'h7E, 1'b0, 8'h00},
    '{8'hFE, 8'hFF, 1'b0, 8'h00},
    '{8'h7E, 8'hFF, 1'b0, 8'h00},
    '{8'hFE, 8'hFF, 1'b0, 8'h00},
    '{8'hFF, 8'hFE, 1'b0, 8'h00},
    '{8'hFE, 8'hFF, 1'b0, 8'h00},
    '{8'hFC, 8'hFF, 1'b0, 8'h00},
    '{8'hAE, 8'hFF, 1'b0, 8'h00},
    '{8'hFC, 8'hFF, 1'b0, 8'h00},
    '{8'hFE, 8'hFF, 1'b0, 8'h00},
    '{8'hFC, 8'hFF, 1'b0, 8'h00},
    '{8'hFE, 8'hFF, 1'b0, 8'h00},
    '{8'hFF, 8'hFF, 1'b0, 8'h00}
  };

  // Controller state as the block should hold it.
  logic [ModeW-1:0]  mode_q;
  logic [FloorW-1:0] floor_q;
  logic [FloorW-1:0] target_q;
  logic [PortW-1:0]  marks_q;
  logic [PortW-1:0]  latch_q;

  logic [PortW-1:0] pending_ports [$];
  int unsigned words_sent;
  int unsigned ports_checked;
  int unsigned trips_started;
  int unsigned floors_counted;
  int unsigned mismatches;
  bit          calm;
  bit          hold_request;

  function automatic logic [PortW-1:0] step_controller(input logic [PortW-1:0] fp,
                                                       input logic [PortW-1:0] bp);
    logic [PortW-1:0] marks;
    int               sel;
    bit               found;
    found = 1'b0;
    case (mode_q)
      MODE_WAITING: begin
        latch_q[OB_LIGHT] = 1'b1;
        for (int i = 0; i < Floors && i < 4; i++) begin
          sel = fp[FP_OCCUPY] ? 2 * i : 2 * i + 1;
          if (!found && !bp[sel]) begin
            target_q = FloorW'(i + 1);
            mode_q = MODE_TRAVEL;
            trips_started++;
            found = 1'b1;
          end
        end
      end
      MODE_TRAVEL: begin
        latch_q[OB_LIGHT] = 1'b0;
        if (fp[FP_DOOR]) begin
          latch_q[OB_MOTOR] = 1'b1;
        end else if (floor_q != target_q) begin
          latch_q[OB_DIR] = floor_q < target_q;
          latch_q[OB_MOTOR] = 1'b0;
          marks = fp | NonMarkMask;
          // Count only on the first mark to fall after all marks were high.
          if (marks_q == AllHigh && marks != AllHigh) begin
            floors_counted++;
            if (latch_q[OB_DIR]) begin
              if (floor_q < Floors) floor_q = floor_q + 1'b1;
            end else if (floor_q > 0) begin
              floor_q = floor_q - 1'b1;
            end
          end
          marks_q = marks;
        end else begin
          latch_q[OB_MOTOR] = 1'b1;
          mode_q = MODE_WAITING;
        end
      end
      default: begin
        if (!fp[FP_GROUND]) begin
          latch_q[OB_MOTOR] = 1'b1;
          floor_q = FloorW'(1);
          mode_q = MODE_WAITING;
        end else begin
          latch_q[OB_MOTOR] = 1'b0;
          latch_q[OB_DIR] = 1'b0;
        end
      end
    endcase
    latch_q[OB_A] = 1'b0;
    latch_q[OB_B] = 1'b0;
    latch_q[OB_C] = 1'b0;
    case (floor_q)
      3'd1: latch_q[OB_A] = 1'b1;
      3'd2: latch_q[OB_B] = 1'b1;
      3'd3: begin
        latch_q[OB_A] = 1'b1;
        latch_q[OB_B] = 1'b1;
      end
      3'd4: latch_q[OB_C] = 1'b1;
      default: ;
    endcase
    // While running an arrow can only be lit; a stop clears both.
    if (!latch_q[OB_MOTOR]) begin
      if (latch_q[OB_DIR]) latch_q[OB_UP] = 1'b0;
      else latch_q[OB_DOWN] = 1'b0;
    end else begin
      latch_q[OB_UP] = 1'b1;
      latch_q[OB_DOWN] = 1'b1;
    end
    return latch_q;
  endfunction

  task automatic offer_word(input logic [PortW-1:0] fp, input logic [PortW-1:0] bp,
                            input logic typed, input logic [PortW-1:0] typed_port);
    logic [PortW-1:0] predicted;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.floor_port  <= fp;
    in_bus.button_port <= bp;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predicted = step_controller(fp, bp);
    pending_ports.push_back(typed ? typed_port : predicted);
    words_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_ports.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk_i) begin : port_check
    logic [PortW-1:0] want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_ports.size() == 0) begin
        $error("output_port: expected no word, actual %h", out_bus.output_port);
        mismatches++;
      end else begin
        want = pending_ports.pop_front();
        if (out_bus.output_port !== want) begin
          $error("output_port: expected %h, actual %h", want, out_bus.output_port);
          mismatches++;
        end
        ports_checked++;
      end
    end
  end

  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) stalled = 0;
      else stalled++;
    end
    $error("no word moved for %0d cycles", StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [PortW-1:0] fp;
    logic [PortW-1:0] bp;
    int unsigned      pick;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.floor_port = AllHigh;
    in_bus.button_port = AllHigh;
    mode_q = MODE_HOMING;
    floor_q = '0;
    target_q = '0;
    marks_q = '0;
    latch_q = AllHigh;
    words_sent = 0;
    ports_checked = 0;
    trips_started = 0;
    floors_counted = 0;
    mismatches = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (call_plan[r]) begin
      offer_word(call_plan[r].fp, call_plan[r].bp, call_plan[r].typed, call_plan[r].port);
    end
    pause_until_drained();

    // Mostly closed doors and alternating marks, so the car keeps moving.
    for (int n = 0; n < RandomWords; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 200) hold_request = 1'b1;
      if (n == 1000) pause_until_drained();
      fp = AllHigh;
      fp[FP_DOOR] = $urandom_range(0, 99) < 15;
      fp[FP_OCCUPY] = 1'($urandom_range(0, 1));
      fp[4] = 1'($urandom_range(0, 1));
      fp[6] = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick >= 5 && pick <= 8) begin
        fp[2 * $urandom_range(0, 3) + 1] = 1'b0;
      end else if (pick == 9) begin
        fp[1] = 1'($urandom_range(0, 1));
        fp[3] = 1'($urandom_range(0, 1));
        fp[5] = 1'($urandom_range(0, 1));
        fp[7] = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 9);
      bp = AllHigh;
      if (pick >= 6 && pick <= 8) bp[$urandom_range(0, 7)] = 1'b0;
      else if (pick == 9) bp = PortW'($urandom_range(0, 255));
      offer_word(fp, bp, 1'b0, '0);
    end

    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Checked %0d of %0d words sent: %0d trips, %0d floor marks counted.",
             ports_checked, words_sent, trips_started, floors_counted);
    $display("Coverage included homing, both call sources, door holds and a stalled sink.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
